// ===== rtl/core/sorted_weight_table_unit_assert.svh =====
// Assertion macros shared by the sorted weight table RTL.
`ifndef SORTED_WEIGHT_TABLE_UNIT_ASSERT_SVH
`define SORTED_WEIGHT_TABLE_UNIT_ASSERT_SVH

// Condition holds at every edge out of reset.
`define SWT_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define SWT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SWT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/swt_pkg.sv =====
// Shared types and constants of the sorted weight table.
`default_nettype none

package swt_pkg;

    localparam int ID_BITS           = 16;
    localparam int WEIGHT_FIELD_BITS = 16;
    localparam int SUM_BITS          = 20;
    localparam int SLOT_BITS         = 4;
    localparam int HELD_BITS         = 5;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DETACH = 1'b1;

    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2
    } swt_status_t;

    typedef struct packed {
        logic                         kind;
        logic [ID_BITS-1:0]           entry_id;
        logic [WEIGHT_FIELD_BITS-1:0] entry_weight;
    } swt_req_t;

    typedef struct packed {
        swt_status_t                  status;
        logic [SLOT_BITS-1:0]         slot;
        logic [WEIGHT_FIELD_BITS-1:0] removed_weight;
        logic [SUM_BITS-1:0]          total_weight;
        logic [HELD_BITS-1:0]         entries_held;
    } swt_rsp_t;

    // Controller to datapath.
    typedef struct packed {
        logic take_req;
        logic head_read;
        logic head_check;
        logic walk;
        logic place;
        logic load_rsp;
    } swt_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic is_detach;
        logic full;
        logic empty;
        logic walk_end;
    } swt_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/swt_stream_if.sv =====
// Valid/ready stream interface carrying one payload type.
`default_nettype none

interface swt_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/swt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module swt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/swt_datapath.sv =====
// Table datapath: entry RAM, walk pointers, totals and result register.
`default_nettype none
`include "sorted_weight_table_unit_assert.svh"

module swt_datapath
    import swt_pkg::*;
#(
    parameter int CAPACITY    = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire swt_cmd_t  cmd,
    output swt_stat_t      stat,
    input  wire swt_req_t  req_payload,
    output swt_rsp_t       rsp_payload
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = ID_BITS + WEIGHT_BITS;

    logic                   kind_reg,      kind_next;
    logic [ID_BITS-1:0]     id_reg,        id_next;
    logic [WEIGHT_BITS-1:0] w_reg,         w_next;
    logic [CW-1:0]          count_reg,     count_next;
    logic [SUM_BITS-1:0]    sum_reg,       sum_next;
    logic [AW-1:0]          ptr_reg,       ptr_next;
    logic [CW-1:0]          rd_left_reg,   rd_left_next;
    logic                   rd_live_reg,   rd_live_next;
    logic [AW-1:0]          rd_idx_reg,    rd_idx_next;
    logic                   head_take_reg, head_take_next;
    logic                   found_reg,     found_next;
    logic [AW-1:0]          pos_reg,       pos_next;
    logic [WEIGHT_BITS-1:0] removed_reg,   removed_next;
    swt_status_t            status_reg,    status_next;
    swt_rsp_t               rsp_reg,       rsp_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [RW-1:0]          ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [RW-1:0]          ram_rdata;

    logic [WEIGHT_BITS-1:0] rd_w;
    logic [ID_BITS-1:0]     rd_id;
    logic                   is_ins;
    logic                   issue;
    logic                   shift;
    logic                   match;
    logic                   last;
    logic                   full;

    swt_ram #(
        .WIDTH (RW),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_w   = ram_rdata[WEIGHT_BITS-1:0];
    assign rd_id  = ram_rdata[WEIGHT_BITS +: ID_BITS];
    assign is_ins = (kind_reg == KIND_INSERT);
    assign issue  = cmd.walk && (rd_left_reg != '0);
    // insert walks from the tail; everything moves down when the new weight is at least the head's
    assign shift  = head_take_reg || (rd_w < w_reg);
    assign match  = (rd_id == id_reg);
    assign last   = rd_live_reg && (rd_left_reg == '0);
    assign full   = (count_reg == CW'(CAPACITY));

    assign ram_raddr = cmd.head_read ? '0 : ptr_reg;

    assign stat.is_detach = (kind_reg == KIND_DETACH);
    assign stat.full      = full;
    assign stat.empty     = (count_reg == '0);
    assign stat.walk_end  = is_ins ? (rd_live_reg && (!shift || last)) : last;

    assign rsp_payload = rsp_reg;

    always_comb
    begin
        kind_next      = kind_reg;
        id_next        = id_reg;
        w_next         = w_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        ptr_next       = ptr_reg;
        rd_left_next   = rd_left_reg;
        rd_live_next   = rd_live_reg;
        rd_idx_next    = rd_idx_reg;
        head_take_next = head_take_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;
        removed_next   = removed_reg;
        status_next    = status_reg;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = {id_reg, w_reg};

        if (cmd.take_req)
        begin
            kind_next    = req_payload.kind;
            id_next      = req_payload.entry_id;
            w_next       = WEIGHT_BITS'(req_payload.entry_weight);
            rd_left_next = count_reg;
            ptr_next     = (req_payload.kind == KIND_INSERT) ?
                           AW'(count_reg - CW'(1)) : '0;
            rd_live_next = 1'b0;
            found_next   = 1'b0;
            pos_next     = '0;
            removed_next = '0;
            if (req_payload.kind == KIND_INSERT)
            begin
                status_next = full ? STATUS_FULL : STATUS_DONE;
            end
            else
            begin
                status_next = STATUS_NOT_FOUND;
            end
        end

        if (cmd.head_check)
        begin
            head_take_next = (w_reg >= rd_w);
        end

        if (cmd.walk)
        begin
            rd_live_next = issue;
            if (issue)
            begin
                rd_idx_next  = ptr_reg;
                rd_left_next = rd_left_reg - CW'(1);
                ptr_next     = is_ins ? (ptr_reg - AW'(1)) : (ptr_reg + AW'(1));
            end

            if (rd_live_reg)
            begin
                if (is_ins)
                begin
                    if (shift)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = rd_idx_reg + AW'(1);
                        ram_wdata = ram_rdata;
                        if (last)
                        begin
                            pos_next = '0;
                        end
                    end
                    else
                    begin
                        pos_next = rd_idx_reg + AW'(1);
                    end
                end
                else
                begin
                    if (found_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = rd_idx_reg - AW'(1);
                        ram_wdata = ram_rdata;
                    end
                    else if (match)
                    begin
                        found_next   = 1'b1;
                        pos_next     = rd_idx_reg;
                        removed_next = rd_w;
                    end
                    if (last && (found_reg || match))
                    begin
                        status_next = STATUS_DONE;
                        count_next  = count_reg - CW'(1);
                        sum_next    = sum_reg -
                                      SUM_BITS'(found_reg ? removed_reg : rd_w);
                    end
                end
            end
        end

        if (cmd.place)
        begin
            ram_we     = 1'b1;
            ram_waddr  = pos_reg;
            ram_wdata  = {id_reg, w_reg};
            count_next = count_reg + CW'(1);
            sum_next   = sum_reg + SUM_BITS'(w_reg);
        end

        if (cmd.load_rsp)
        begin
            rsp_next.status         = status_reg;
            rsp_next.slot           = SLOT_BITS'(pos_reg);
            rsp_next.removed_weight = WEIGHT_FIELD_BITS'(removed_reg);
            rsp_next.total_weight   = sum_reg;
            rsp_next.entries_held   = HELD_BITS'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            sum_reg     <= '0;
            rd_live_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            rd_live_reg <= rd_live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        id_reg        <= id_next;
        w_reg         <= w_next;
        ptr_reg       <= ptr_next;
        rd_left_reg   <= rd_left_next;
        rd_idx_reg    <= rd_idx_next;
        head_take_reg <= head_take_next;
        found_reg     <= found_next;
        pos_reg       <= pos_next;
        removed_reg   <= removed_next;
        status_reg    <= status_next;
        rsp_reg       <= rsp_next;
    end

    `SWT_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(CAPACITY), "entry count above capacity")
    `SWT_ASSERT_IMPL(a_place_room, cmd.place, !full, "insert placed into a full table")
    `SWT_ASSERT_IMPL(a_detach_shift_idx, cmd.walk && rd_live_reg && !is_ins && found_reg, rd_idx_reg != '0, "detach shift below head")

endmodule

`default_nettype wire

// ===== rtl/core/swt_controller.sv =====
// Sequencer for one request at a time: dispatch, table walk, placement, result.
`default_nettype none
`include "sorted_weight_table_unit_assert.svh"

module swt_controller
    import swt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_ready,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output swt_cmd_t       cmd,
    input  wire swt_stat_t stat
);

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_DISPATCH  = 7'b0000010,
        ST_INS_CHECK = 7'b0000100,
        ST_INS_WALK  = 7'b0001000,
        ST_PLACE     = 7'b0010000,
        ST_DET_WALK  = 7'b0100000,
        ST_FINISH    = 7'b1000000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        accept;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        cmd            = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.take_req = 1'b1;
                    state_next   = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                // head read is issued unconditionally; only the insert path uses it
                cmd.head_read = 1'b1;
                if (stat.is_detach)
                begin
                    state_next = stat.empty ? ST_FINISH : ST_DET_WALK;
                end
                else if (stat.full)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = stat.empty ? ST_PLACE : ST_INS_CHECK;
                end
            end
            ST_INS_CHECK:
            begin
                cmd.head_check = 1'b1;
                cmd.walk       = 1'b1;
                state_next     = ST_INS_WALK;
            end
            ST_INS_WALK:
            begin
                cmd.walk = 1'b1;
                if (stat.walk_end)
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_DET_WALK:
            begin
                cmd.walk = 1'b1;
                if (stat.walk_end)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.load_rsp   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `SWT_ASSERT_NEXT(a_accept_dispatch, accept, state_reg == ST_DISPATCH, "request not dispatched")
    `SWT_ASSERT_NEXT(a_finish_hold, state_reg == ST_FINISH && out_valid_reg && !rsp_ready, state_reg == ST_FINISH, "result overwritten while stalled")
    `SWT_ASSERT_NEXT(a_load_valid, cmd.load_rsp, out_valid_reg, "loaded result not presented")

endmodule

`default_nettype wire

// ===== rtl/core/sorted_weight_table_unit.sv =====
// Top level of the sorted weight table: controller, datapath and stream ports.
// Holds up to CAPACITY (id, weight) entries in descending weight order in a
// single-port-read RAM, with the running weight total and entry count. One
// request is handled at a time and gives exactly one result. The walk over the
// entry RAM, one entry per cycle through its registered read port, sets the
// time: an insert walks from the tail until the new entry's place is found,
// and does no walk into an empty table; a detach walks every entry held; a
// refused insert or a detach from an empty table does no walk. A new request
// is taken once the previous result is loaded into the output register, which
// holds it until the sink takes it. The entry RAM needs no clearing after
// reset, since only positions below the count are read.
`default_nettype none

module sorted_weight_table_unit
    import swt_pkg::*;
#(
    parameter int CAPACITY    = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    swt_stream_if.sink   request,
    swt_stream_if.source result
);

    swt_cmd_t  cmd;
    swt_stat_t stat;
    logic      req_ready;
    logic      rsp_valid;
    swt_rsp_t  rsp_payload;
    swt_req_t  req_payload;

    assign req_payload    = request.payload;
    assign request.ready  = req_ready;
    assign result.valid   = rsp_valid;
    assign result.payload = rsp_payload;

    swt_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (result.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    swt_datapath #(
        .CAPACITY    (CAPACITY),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_payload (req_payload),
        .rsp_payload (rsp_payload)
    );

endmodule

`default_nettype wire

// ===== sim/swt_table_checker.sv =====
// Checker for the sorted weight table: predicts each result and compares it with the block's output.
`default_nettype none

module swt_table_checker
    import swt_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     request_valid,
    input  logic     request_ready,
    input  swt_req_t request_payload,
    input  logic     result_valid,
    input  logic     result_ready,
    input  swt_rsp_t result_payload,
    output int       mismatches,
    output int       pending
);

    logic [ID_BITS-1:0]           table_ids     [CAPACITY];
    logic [WEIGHT_FIELD_BITS-1:0] table_weights [CAPACITY];
    int                           table_held;
    logic [SUM_BITS-1:0]          table_total;
    swt_rsp_t                     expected_results [$];

    // Applies one request to the shadow table and returns the result it gives.
    function automatic swt_rsp_t apply_request(input swt_req_t req);
        swt_rsp_t                     rsp;
        int                           pos;
        int                           i;
        logic [WEIGHT_FIELD_BITS-1:0] w;
        rsp = '0;
        pos = 0;
        w = req.entry_weight;
        if (req.kind == KIND_INSERT)
        begin
            if (table_held >= CAPACITY)
            begin
                rsp.status = STATUS_FULL;
            end
            else
            begin
                // new entry goes behind every entry of equal or larger weight,
                // except that a weight at least the head's goes first
                if (table_held != 0 && w < table_weights[0])
                begin
                    while (pos < table_held && table_weights[pos] >= w)
                        pos++;
                end
                for (i = table_held; i > pos; i--)
                begin
                    table_ids[i]     = table_ids[i-1];
                    table_weights[i] = table_weights[i-1];
                end
                table_ids[pos]     = req.entry_id;
                table_weights[pos] = w;
                table_held++;
                table_total = table_total + SUM_BITS'(w);
                rsp.status = STATUS_DONE;
                rsp.slot   = SLOT_BITS'(pos);
            end
        end
        else
        begin
            while (pos < table_held && table_ids[pos] != req.entry_id)
                pos++;
            if (pos >= table_held)
            begin
                rsp.status = STATUS_NOT_FOUND;
            end
            else
            begin
                w = table_weights[pos];
                for (i = pos; i + 1 < table_held; i++)
                begin
                    table_ids[i]     = table_ids[i+1];
                    table_weights[i] = table_weights[i+1];
                end
                table_held--;
                table_total = table_total - SUM_BITS'(w);
                rsp.status         = STATUS_DONE;
                rsp.slot           = SLOT_BITS'(pos);
                rsp.removed_weight = w;
            end
        end
        rsp.total_weight = table_total;
        rsp.entries_held = HELD_BITS'(table_held);
        return rsp;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        swt_rsp_t exp_rsp;
        if (!rst_n)
        begin
            table_held  = 0;
            table_total = '0;
            mismatches  = 0;
            expected_results.delete();
        end
        else
        begin
            if (request_valid && request_ready)
                expected_results.push_back(apply_request(request_payload));
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result with no request outstanding: status=%0d slot=%0d",
                                 $realtime, result_payload.status, result_payload.slot);
                    mismatches++;
                end
                else
                begin
                    exp_rsp = expected_results.pop_front();
                    if (result_payload.status !== exp_rsp.status
                        || result_payload.slot !== exp_rsp.slot
                        || result_payload.removed_weight !== exp_rsp.removed_weight
                        || result_payload.total_weight !== exp_rsp.total_weight
                        || result_payload.entries_held !== exp_rsp.entries_held)
                    begin
                        if (mismatches < 10)
                            $display({"%0t: mismatch: expected status=%0d slot=%0d removed=%0d ",
                                      "total=%0d held=%0d, got status=%0d slot=%0d removed=%0d ",
                                      "total=%0d held=%0d"},
                                     $realtime, exp_rsp.status, exp_rsp.slot,
                                     exp_rsp.removed_weight, exp_rsp.total_weight,
                                     exp_rsp.entries_held, result_payload.status,
                                     result_payload.slot, result_payload.removed_weight,
                                     result_payload.total_weight, result_payload.entries_held);
                        mismatches++;
                    end
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Top of the sorted weight table testbench: clock, reset, request and result traffic, verdict.
`default_nettype none

module testbench;
    import swt_pkg::*;

    localparam int STALL_LIMIT     = 5000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int ITEMS_PER_PHASE = 350;
    localparam int DRAIN_CYCLES    = 40;
    localparam int ID_POOL_DEPTH   = 64;

    logic clk = 1'b0;
    logic rst_n;

    int   mismatch_count;
    int   results_owed;
    int   send_idle_pct = 0;
    int   rsp_stall_pct = 0;
    bit   hold_off_req  = 1'b0;
    int   idle_cycles   = 0;

    logic [ID_BITS-1:0] live_ids [$];

    swt_stream_if #(.payload_t(swt_req_t)) request_ch ();
    swt_stream_if #(.payload_t(swt_rsp_t)) result_ch ();

    sorted_weight_table_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_ch),
        .result  (result_ch)
    );

    swt_table_checker table_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .request_valid   (request_ch.valid),
        .request_ready   (request_ch.ready),
        .request_payload (request_ch.payload),
        .result_valid    (result_ch.valid),
        .result_ready    (result_ch.ready),
        .result_payload  (result_ch.payload),
        .mismatches      (mismatch_count),
        .pending         (results_owed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: random stalls, plus a long hold-off on demand.
    initial
    begin : result_side
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_done)
            begin
                hold_left = HOLD_OFF_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((request_ch.valid && request_ch.ready) || (result_ch.valid && result_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL sorted_weight_table_unit");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_request(input logic kind, input logic [ID_BITS-1:0] id,
                                input logic [WEIGHT_FIELD_BITS-1:0] weight);
        swt_req_t req;
        req.kind         = kind;
        req.entry_id     = id;
        req.entry_weight = weight;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            request_ch.valid <= 1'b0;
            @(posedge clk);
        end
        request_ch.payload <= req;
        request_ch.valid   <= 1'b1;
        @(posedge clk);
        while (!request_ch.ready)
            @(posedge clk);
    endtask

    initial
    begin
        int                           phase;
        int                           n;
        int                           k;
        int                           insert_pct;
        logic                         kind;
        logic [ID_BITS-1:0]           id;
        logic [WEIGHT_FIELD_BITS-1:0] weight;

        request_ch.valid   = 1'b0;
        request_ch.payload = '0;
        rst_n              = 1'b0;
        insert_pct         = 50;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, head and tail ties, duplicate ids, filling up
        send_request(KIND_DETACH, 16'd5,      16'hFFFF);
        send_request(KIND_INSERT, 16'h0000,   16'd0);
        send_request(KIND_INSERT, 16'hFFFF,   16'hFFFF);
        send_request(KIND_INSERT, 16'h1234,   16'd100);
        send_request(KIND_INSERT, 16'h1234,   16'd100);
        send_request(KIND_INSERT, 16'd7,      16'hFFFF);
        send_request(KIND_INSERT, 16'd8,      16'd0);
        send_request(KIND_DETACH, 16'h1234,   16'd0);
        send_request(KIND_DETACH, 16'h1234,   16'd0);
        send_request(KIND_DETACH, 16'h1234,   16'd0);
        send_request(KIND_DETACH, 16'hFFFF,   16'd0);
        send_request(KIND_DETACH, 16'h0000,   16'd0);
        send_request(KIND_INSERT, 16'hAAAA,   16'h5555);
        send_request(KIND_INSERT, 16'h5555,   16'hAAAA);
        for (n = 0; n < 12; n++)
            send_request(KIND_INSERT, 16'h0100 + 16'(n),
                         (n % 2 == 1) ? 16'(n * 4000) : 16'(60000 - n * 3000));
        send_request(KIND_INSERT, 16'hFFFF, 16'h8000);

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
                1: begin send_idle_pct = 53; rsp_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rsp_stall_pct = 53; end
                default: begin send_idle_pct = 9; rsp_stall_pct = 9; end
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // swing the fill level so the table both fills and drains
                if (n % 50 == 0)
                begin
                    case ($urandom_range(0, 2))
                        0: insert_pct = 85;
                        1: insert_pct = 55;
                        default: insert_pct = 30;
                    endcase
                end
                if (phase == 0 && n == 120)
                    hold_off_req = 1'b1;

                weight = 16'($urandom_range(0, 65535));
                if ($urandom_range(0, 3) == 0)
                begin
                    case ($urandom_range(0, 2))
                        0: weight = 16'd0;
                        1: weight = 16'hFFFF;
                        default: weight = 16'($urandom_range(0, 3) * 20000);
                    endcase
                end
                if ($urandom_range(0, 99) < insert_pct)
                begin
                    kind = KIND_INSERT;
                    if ($urandom_range(0, 1) == 1)
                        id = 16'($urandom_range(0, 15));
                    else
                        id = 16'($urandom_range(0, 65535));
                    if (live_ids.size() >= ID_POOL_DEPTH)
                        void'(live_ids.pop_front());
                    live_ids.push_back(id);
                end
                else
                begin
                    kind = KIND_DETACH;
                    if (live_ids.size() > 0 && $urandom_range(0, 3) != 0)
                    begin
                        k  = $urandom_range(0, live_ids.size() - 1);
                        id = live_ids[k];
                        live_ids.delete(k);
                    end
                    else
                    begin
                        id = 16'($urandom_range(0, 65535));
                    end
                end
                send_request(kind, id, weight);
            end
        end
        request_ch.valid <= 1'b0;

        // let the checker count the last request before waiting on it
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS sorted_weight_table_unit");
        else
            $display("FAIL sorted_weight_table_unit");
        $finish;
    end

endmodule

`default_nettype wire
